@@ rtl/uf_pkg.sv @@
// shared types and constants for the union-find table
// used by union_find_by_size_unit and the testbench
package uf_pkg;

  localparam int N_ELEMENTS = 1024;
  localparam int IDX_W      = $clog2(N_ELEMENTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int CMD_W      = 2;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [CMD_W-1:0] cmd_t;

  localparam cmd_t CMD_FIND  = 2'd0;
  localparam cmd_t CMD_UNION = 2'd1;
  localparam cmd_t CMD_SIZE  = 2'd2;

  localparam cnt_t CNT_ONE = cnt_t'(1);
  localparam cnt_t CNT_ALL = cnt_t'(N_ELEMENTS);
  localparam idx_t IDX_LAST = idx_t'(N_ELEMENTS - 1);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK_REQ,
    S_WALK_CHK,
    S_COMP_REQ,
    S_COMP_CHK,
    S_SZ_A_REQ,
    S_SZ_A_GET,
    S_SZ_B_GET,
    S_LINK,
    S_FIN
  } state_t;

endpackage

@@ rtl/uf_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module uf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/union_find_by_size_unit.sv @@
// disjoint-set table, union by size with full path compression
// depends on uf_pkg and uf_ram
//
// Input channel: in_valid/in_stall carrying in_command, in_elem_a and
// in_elem_b. Command 0 finds elem_a's root, 1 joins the sets of elem_a and
// elem_b, 2 returns the size of elem_a's set; code 3 acts as a find.
// Result channel: out_valid/out_stall carrying the root and set size of
// elem_a after the command, the merged flag and the current set count.
// Exactly one result item per input item, in order.
// One item is worked at a time. A find or size query walks from elem_a to
// its root, then walks the path again pointing each node at the root, then
// reads the set size; a union also walks and compresses elem_b's path (after
// elem_a's path is compressed) and, when the roots differ, reads both sizes
// and links the smaller set's root under the other's, a's under b's on a tie.
// The walk and the compression each visit one node at a time, paced by the
// single read port of the parent memory; sizes are read one at a time from
// the size memory. After reset the block runs a clearing pass, writing every
// parent entry with its own index and every size entry with one, and holds
// in_stall high meanwhile. A result waiting on a stalled receiver sits in
// the output register; the next item is still accepted and worked, and the
// block waits only when that next result is ready to be loaded.
module union_find_by_size_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_command,
  input  logic [9:0]          in_elem_a,
  input  logic [9:0]          in_elem_b,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [9:0]          out_representative,
  output logic [10:0]         out_set_size,
  output logic                out_merged,
  output logic [10:0]         out_component_count
);

  uf_pkg::state_t state_r, state_nxt;

  uf_pkg::idx_t clr_r, clr_nxt;
  uf_pkg::idx_t start_r, start_nxt;
  uf_pkg::idx_t node_r, node_nxt;
  uf_pkg::idx_t root_r, root_nxt;
  uf_pkg::idx_t elem_b_r, elem_b_nxt;
  uf_pkg::idx_t ra_r, ra_nxt;
  uf_pkg::idx_t rb_r, rb_nxt;
  uf_pkg::cnt_t size_a_r, size_a_nxt;
  uf_pkg::cnt_t size_b_r, size_b_nxt;
  uf_pkg::cnt_t comp_r, comp_nxt;
  logic         union_r, union_nxt;
  logic         phase_r, phase_nxt;

  uf_pkg::idx_t res_root_r, res_root_nxt;
  uf_pkg::cnt_t res_size_r, res_size_nxt;
  logic         res_merged_r, res_merged_nxt;

  logic         out_valid_r, out_valid_nxt;
  uf_pkg::idx_t out_root_r, out_root_nxt;
  uf_pkg::cnt_t out_size_r, out_size_nxt;
  logic         out_merged_r, out_merged_nxt;
  uf_pkg::cnt_t out_comp_r, out_comp_nxt;

  // memory ports
  logic         p_we;
  uf_pkg::idx_t p_waddr, p_wdata, p_raddr, p_rdata;
  logic         s_we;
  uf_pkg::idx_t s_waddr, s_raddr;
  uf_pkg::cnt_t s_wdata, s_rdata;

  // shared compare and add unit
  uf_pkg::idx_t cmp_x, cmp_y;
  logic         cmp_eq;
  logic         a_le_b;
  uf_pkg::cnt_t size_sum;

  logic accept;
  logic is_union;
  logic out_free;
  logic link_needed;

  assign cmp_eq   = (cmp_x == cmp_y);
  assign a_le_b   = (size_a_r <= size_b_r);
  assign size_sum = size_a_r + size_b_r;

  assign accept      = in_valid && (state_r == uf_pkg::S_IDLE);
  assign out_free    = !out_valid_r || !out_stall;
  assign link_needed = union_r && (ra_r != rb_r);

  always_comb begin
    case (in_command)
      uf_pkg::CMD_UNION: is_union = 1'b1;
      uf_pkg::CMD_FIND,
      uf_pkg::CMD_SIZE:  is_union = 1'b0;
      default:           is_union = 1'b0;
    endcase
  end

  uf_ram #(.WIDTH(uf_pkg::IDX_W), .DEPTH(uf_pkg::N_ELEMENTS)) u_parent (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  uf_ram #(.WIDTH(uf_pkg::CNT_W), .DEPTH(uf_pkg::N_ELEMENTS)) u_size (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      uf_pkg::S_CLEAR: begin
        if (clr_r == uf_pkg::IDX_LAST) state_nxt = uf_pkg::S_IDLE;
      end
      uf_pkg::S_IDLE: begin
        if (accept) state_nxt = uf_pkg::S_WALK_REQ;
      end
      uf_pkg::S_WALK_REQ: state_nxt = uf_pkg::S_WALK_CHK;
      uf_pkg::S_WALK_CHK: begin
        if (cmp_eq) state_nxt = uf_pkg::S_COMP_REQ;
      end
      uf_pkg::S_COMP_REQ: state_nxt = uf_pkg::S_COMP_CHK;
      uf_pkg::S_COMP_CHK: begin
        if (cmp_eq) begin
          if (!phase_r && union_r) state_nxt = uf_pkg::S_WALK_REQ;
          else                     state_nxt = uf_pkg::S_SZ_A_REQ;
        end
      end
      uf_pkg::S_SZ_A_REQ: state_nxt = uf_pkg::S_SZ_A_GET;
      uf_pkg::S_SZ_A_GET: begin
        if (link_needed) state_nxt = uf_pkg::S_SZ_B_GET;
        else             state_nxt = uf_pkg::S_FIN;
      end
      uf_pkg::S_SZ_B_GET: state_nxt = uf_pkg::S_LINK;
      uf_pkg::S_LINK:     state_nxt = uf_pkg::S_FIN;
      uf_pkg::S_FIN: begin
        if (out_free) state_nxt = uf_pkg::S_IDLE;
      end
      default: state_nxt = uf_pkg::S_CLEAR;
    endcase
  end

  // compare operands: a node against its parent while walking, else against the root
  always_comb begin
    cmp_x = node_r;
    cmp_y = root_r;
    if (state_r == uf_pkg::S_WALK_CHK) begin
      // a node whose parent is itself is the root
      cmp_x = p_rdata;
      cmp_y = node_r;
    end
  end

  // memory controls and handshake
  always_comb begin
    p_we    = 1'b0;
    p_waddr = node_r;
    p_wdata = root_r;
    p_raddr = node_r;
    s_we    = 1'b0;
    s_waddr = rb_r;
    s_wdata = size_sum;
    s_raddr = ra_r;
    in_stall = (state_r != uf_pkg::S_IDLE);
    case (state_r)
      uf_pkg::S_CLEAR: begin
        p_we    = 1'b1;
        p_waddr = clr_r;
        p_wdata = clr_r;
        s_we    = 1'b1;
        s_waddr = clr_r;
        s_wdata = uf_pkg::CNT_ONE;
      end
      uf_pkg::S_WALK_CHK: begin
        if (!cmp_eq) p_raddr = p_rdata;
      end
      uf_pkg::S_COMP_CHK: begin
        if (!cmp_eq) begin
          p_we    = 1'b1;
          p_raddr = p_rdata;
        end
      end
      uf_pkg::S_SZ_A_GET: s_raddr = rb_r;
      uf_pkg::S_LINK: begin
        s_we = 1'b1;
        p_we = 1'b1;
        if (a_le_b) begin
          p_waddr = ra_r;
          p_wdata = rb_r;
          s_waddr = rb_r;
        end else begin
          p_waddr = rb_r;
          p_wdata = ra_r;
          s_waddr = ra_r;
        end
      end
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    clr_nxt        = clr_r;
    start_nxt      = start_r;
    node_nxt       = node_r;
    root_nxt       = root_r;
    elem_b_nxt     = elem_b_r;
    ra_nxt         = ra_r;
    rb_nxt         = rb_r;
    size_a_nxt     = size_a_r;
    size_b_nxt     = size_b_r;
    comp_nxt       = comp_r;
    union_nxt      = union_r;
    phase_nxt      = phase_r;
    res_root_nxt   = res_root_r;
    res_size_nxt   = res_size_r;
    res_merged_nxt = res_merged_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_root_nxt   = out_root_r;
    out_size_nxt   = out_size_r;
    out_merged_nxt = out_merged_r;
    out_comp_nxt   = out_comp_r;
    case (state_r)
      uf_pkg::S_CLEAR: clr_nxt = clr_r + uf_pkg::idx_t'(1);
      uf_pkg::S_IDLE: begin
        if (accept) begin
          start_nxt  = in_elem_a[uf_pkg::IDX_W-1:0];
          node_nxt   = in_elem_a[uf_pkg::IDX_W-1:0];
          elem_b_nxt = in_elem_b[uf_pkg::IDX_W-1:0];
          union_nxt  = is_union;
          phase_nxt  = 1'b0;
        end
      end
      uf_pkg::S_WALK_CHK: begin
        if (cmp_eq) begin
          root_nxt = node_r;
          node_nxt = start_r;
        end else begin
          node_nxt = p_rdata;
        end
      end
      uf_pkg::S_COMP_CHK: begin
        if (cmp_eq) begin
          if (!phase_r) begin
            ra_nxt = root_r;
            if (union_r) begin
              phase_nxt = 1'b1;
              start_nxt = elem_b_r;
              node_nxt  = elem_b_r;
            end
          end else begin
            rb_nxt = root_r;
          end
        end else begin
          node_nxt = p_rdata;
        end
      end
      uf_pkg::S_SZ_A_GET: begin
        size_a_nxt     = s_rdata;
        res_root_nxt   = ra_r;
        res_size_nxt   = s_rdata;
        res_merged_nxt = 1'b0;
      end
      uf_pkg::S_SZ_B_GET: size_b_nxt = s_rdata;
      uf_pkg::S_LINK: begin
        res_root_nxt   = a_le_b ? rb_r : ra_r;
        res_size_nxt   = size_sum;
        res_merged_nxt = 1'b1;
        comp_nxt       = comp_r - uf_pkg::CNT_ONE;
      end
      uf_pkg::S_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_root_nxt   = res_root_r;
          out_size_nxt   = res_size_r;
          out_merged_nxt = res_merged_r;
          out_comp_nxt   = comp_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= uf_pkg::S_CLEAR;
      clr_r       <= '0;
      comp_r      <= uf_pkg::CNT_ALL;
      out_valid_r <= 1'b0;
      union_r     <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      comp_r      <= comp_nxt;
      out_valid_r <= out_valid_nxt;
      union_r     <= union_nxt;
      phase_r     <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r      <= start_nxt;
    node_r       <= node_nxt;
    root_r       <= root_nxt;
    elem_b_r     <= elem_b_nxt;
    ra_r         <= ra_nxt;
    rb_r         <= rb_nxt;
    size_a_r     <= size_a_nxt;
    size_b_r     <= size_b_nxt;
    res_root_r   <= res_root_nxt;
    res_size_r   <= res_size_nxt;
    res_merged_r <= res_merged_nxt;
    out_root_r   <= out_root_nxt;
    out_size_r   <= out_size_nxt;
    out_merged_r <= out_merged_nxt;
    out_comp_r   <= out_comp_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_representative  = out_root_r;
  assign out_set_size        = out_size_r;
  assign out_merged          = out_merged_r;
  assign out_component_count = out_comp_r;

  // set count stays within one and the element count
  a_comp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (comp_r != '0) && (comp_r <= uf_pkg::CNT_ALL))
    else $error("component count out of range");

  // every link removes exactly one set
  a_link_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == uf_pkg::S_LINK) |=> (comp_r == $past(comp_r) - uf_pkg::CNT_ONE))
    else $error("link did not drop the component count");

  // a result appears only when the sequencer hands one over
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == uf_pkg::S_FIN))
    else $error("result raised outside the hand-over state");

  // no item is taken while the tables are being cleared
  a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == uf_pkg::S_CLEAR) |-> in_stall)
    else $error("input taken during clearing pass");

  // a merge is only reported for a union of two different roots
  a_merge_union: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == uf_pkg::S_LINK) |-> (union_r && (ra_r != rb_r)))
    else $error("link without a union of distinct roots");

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// self-checking bench for union_find_by_size_unit: directed and random commands
// against a disjoint-set tracker held in a small scoreboard class; needs uf_pkg
module testbench;
  import uf_pkg::*;

  localparam cmd_t CMD_SPARE   = 2'd3;  // unused code, worked as a find
  localparam int   CYCLE_LIMIT = 1000000;
  localparam int   HOLD_AT     = 150;
  localparam int   HOLD_CYCLES = 300;

  typedef struct {
    idx_t representative;
    cnt_t set_size;
    logic merged;
    cnt_t component_count;
  } set_answer_t;

  class disjoint_set_tracker;
    idx_t        parent[N_ELEMENTS];
    cnt_t        set_size_of[N_ELEMENTS];
    cnt_t        sets_left;
    set_answer_t answers_due[$];
    int          error_count;
    int          answers_seen;
    int          n_find, n_union, n_merge, n_size, n_spare, deepest;

    function new();
      for (int i = 0; i < N_ELEMENTS; i++) begin
        parent[i]      = idx_t'(i);
        set_size_of[i] = CNT_ONE;
      end
      sets_left = CNT_ALL;
    endfunction

    // walk to the root, then point the whole path at it
    function idx_t root_compress(idx_t x);
      idx_t r, nxt;
      int   links;
      r = x;
      links = 0;
      while (parent[r] != r) begin
        r = parent[r];
        links++;
      end
      if (links > deepest) deepest = links;
      while (x != r) begin
        nxt = parent[x];
        parent[x] = r;
        x = nxt;
      end
      return r;
    endfunction

    function void apply_command(cmd_t cmd, idx_t a, idx_t b);
      set_answer_t ans;
      idx_t        ra, rb;
      ra = root_compress(a);
      ans.merged = 1'b0;
      case (cmd)
        CMD_FIND:  n_find++;
        CMD_SIZE:  n_size++;
        CMD_SPARE: n_spare++;
        default:   n_union++;
      endcase
      if (cmd == CMD_UNION) begin
        rb = root_compress(b);
        if (ra != rb) begin
          ans.merged = 1'b1;
          n_merge++;
          sets_left = sets_left - CNT_ONE;
          // ties put a's root under b's
          if (set_size_of[ra] <= set_size_of[rb]) begin
            parent[ra] = rb;
            set_size_of[rb] = set_size_of[rb] + set_size_of[ra];
            ra = rb;
          end else begin
            parent[rb] = ra;
            set_size_of[ra] = set_size_of[ra] + set_size_of[rb];
          end
        end
      end
      ans.representative  = ra;
      ans.set_size        = set_size_of[ra];
      ans.component_count = sets_left;
      answers_due.insert(answers_due.size(), ans);
    endfunction

    function void check_answer(idx_t rep, cnt_t sz, logic mg, cnt_t cc);
      set_answer_t e;
      answers_seen++;
      if (answers_due.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("result item %0d arrived with nothing outstanding: %s %0d size %0d",
                   answers_seen, "root", rep, sz);
        return;
      end
      e = answers_due.pop_front();
      if (e.representative !== rep || e.set_size !== sz || e.merged !== mg ||
          e.component_count !== cc) begin
        error_count++;
        if (error_count <= 10)
          $display({"result item %0d: expected root %0d size %0d merged %0b sets %0d,",
                    " got %0d %0d %0b %0d"},
                   answers_seen, e.representative, e.set_size, e.merged,
                   e.component_count, rep, sz, mg, cc);
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_command;
  logic [9:0] in_elem_a;
  logic [9:0] in_elem_b;
  logic       out_valid;
  logic       out_stall;
  logic [9:0] out_representative;
  logic [10:0] out_set_size;
  logic       out_merged;
  logic [10:0] out_component_count;

  disjoint_set_tracker tracker = new();
  int   cycle_count = 0;
  bit   sender_relaxed = 1'b1;
  bit   receiver_relaxed = 1'b1;
  idx_t window_base = '0;

  union_find_by_size_unit DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_command          (in_command),
    .in_elem_a           (in_elem_a),
    .in_elem_b           (in_elem_b),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_representative  (out_representative),
    .out_set_size        (out_set_size),
    .out_merged          (out_merged),
    .out_component_count (out_component_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // valid stays high straight into the next item when there is no gap
  task automatic send_command(input cmd_t cmd, input idx_t a, input idx_t b);
    int gap;
    if ($urandom_range(0, 63) == 0) sender_relaxed = ~sender_relaxed;
    gap = sender_relaxed ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_elem_a  <= a;
    in_elem_b  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.apply_command(cmd, a, b);
  endtask

  // drop valid so the last item is not offered again while draining
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.answers_due.size() != 0) @(posedge clk);
  endtask

  // half the picks fall in a narrow window so sets grow and paths deepen
  function automatic idx_t pick_elem();
    if ($urandom_range(0, 1)) return idx_t'($urandom);
    return window_base + idx_t'($urandom_range(0, 47));
  endfunction

  function automatic cmd_t pick_command();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return CMD_UNION;
    if (roll < 75) return CMD_FIND;
    if (roll < 95) return CMD_SIZE;
    return CMD_SPARE;
  endfunction

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        tracker.check_answer(out_representative, out_set_size, out_merged,
                             out_component_count);
        if ($urandom_range(0, 63) == 0) receiver_relaxed = ~receiver_relaxed;
        stall_left = receiver_relaxed ? $urandom_range(0, 5) : 0;
        // long hold-off so the block backs up into its input
        if (tracker.answers_seen == HOLD_AT) stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("union_find_by_size_unit test failed");
    $finish;
  end

  initial begin : stimulus
    cmd_t cmd;
    idx_t a, b;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_command <= CMD_FIND;
    in_elem_a  <= '0;
    in_elem_b  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, every command, ties, self unions, path compression
    send_command(CMD_FIND,  10'd0,    IDX_LAST);
    send_command(CMD_FIND,  IDX_LAST, 10'd0);
    send_command(CMD_SIZE,  10'd512,  10'd511);
    send_command(CMD_SPARE, IDX_LAST, 10'd0);
    send_command(CMD_UNION, 10'd0,    10'd1);
    send_command(CMD_UNION, 10'd0,    10'd1);
    send_command(CMD_UNION, 10'd1,    10'd0);
    send_command(CMD_UNION, 10'd2,    10'd0);
    send_command(CMD_UNION, 10'd3,    10'd4);
    send_command(CMD_UNION, 10'd4,    10'd0);
    send_command(CMD_FIND,  10'd3,    10'd682);
    send_command(CMD_SIZE,  10'd3,    10'd341);
    send_command(CMD_UNION, IDX_LAST, 10'd1022);
    send_command(CMD_UNION, 10'd1022, IDX_LAST);
    send_command(CMD_UNION, 10'd5,    10'd5);
    send_command(CMD_UNION, IDX_LAST, 10'd0);
    send_command(CMD_SIZE,  IDX_LAST, 10'd0);
    send_command(CMD_SPARE, 10'd1022, 10'd512);
    send_command(CMD_UNION, 10'd512,  10'd511);
    send_command(CMD_UNION, 10'd510,  10'd509);
    send_command(CMD_UNION, 10'd512,  10'd510);
    send_command(CMD_FIND,  10'd509,  IDX_LAST);
    wait_drained();

    // random commands over a moving window
    for (int i = 0; i < 550; i++) begin
      if (i % 100 == 0) window_base = idx_t'($urandom);
      cmd = pick_command();
      a = pick_elem();
      b = pick_elem();
      send_command(cmd, a, b);
    end

    // sender pauses until everything is back, then joins every set
    wait_drained();
    for (int i = 1; i < N_ELEMENTS; i++) begin
      a = idx_t'(i);
      b = idx_t'($urandom_range(0, i - 1));
      if ($urandom_range(0, 3) == 0)
        send_command($urandom_range(0, 1) ? CMD_FIND : CMD_SIZE,
                     pick_elem(), pick_elem());
      if ($urandom_range(0, 1)) send_command(CMD_UNION, a, b);
      else send_command(CMD_UNION, b, a);
    end
    for (int i = 0; i < 12; i++) begin
      cmd = pick_command();
      send_command(cmd, idx_t'($urandom), idx_t'($urandom));
    end

    wait_drained();
    repeat (100) @(posedge clk);
    $display("commands: %0d finds, %0d size queries, %0d spare-code finds, %s",
             tracker.n_find, tracker.n_size, tracker.n_spare,
             $sformatf("%0d unions (%0d merged)", tracker.n_union, tracker.n_merge));
    $display("longest walk %0d links, %0d sets left, %0d errors",
             tracker.deepest, tracker.sets_left, tracker.error_count);
    if (tracker.error_count == 0 && tracker.answers_due.size() == 0) begin
      $display("union_find_by_size_unit test passed");
    end else begin
      $display("union_find_by_size_unit test failed");
    end
    $finish;
  end

endmodule

@@ union_find_by_size_unit.f @@
rtl/uf_pkg.sv
rtl/uf_ram.sv
rtl/union_find_by_size_unit.sv
tb/sv/testbench.sv
